[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the telemetry decoder RTL
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every edge.
`define GTCD_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define GTCD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GTCD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gtcd_pkg.sv]
// ---------------------------------------------------------------------------
// gtcd_pkg
// Types, constants and the GCR quintet table of the telemetry decoder.
// ---------------------------------------------------------------------------
package gtcd_pkg;

    localparam int CAPTURE_W       = 16;
    localparam int VALUE_W         = 12;
    localparam int TICKS_W         = 8;
    localparam int FRAME_BITS      = 21;
    localparam int TOTAL_W         = 5;
    localparam int NUM_W           = CAPTURE_W + 1;
    localparam int REM_W           = 13;    // holds 22 * 255
    localparam int DIV_STEPS       = 5;     // quotient bits, run <= 21
    localparam int CNT_W           = 3;
    localparam int QUINTET_W       = 5;
    localparam int NIBBLE_W        = 4;
    localparam int DEC_W           = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    typedef logic [CAPTURE_W-1:0]  cap_t;
    typedef logic [VALUE_W-1:0]    value_t;
    typedef logic [TICKS_W-1:0]    ticks_t;
    typedef logic [FRAME_BITS-1:0] frame_t;
    typedef logic [TOTAL_W-1:0]    total_t;
    typedef logic [TOTAL_W:0]      total_sum_t;
    typedef logic [NUM_W-1:0]      num_t;
    typedef logic [REM_W-1:0]      rem_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [NIBBLE_W-1:0]   nibble_t;
    typedef logic [DEC_W-1:0]      dec_t;
    typedef logic [APB_DATA_W-1:0] apb_data_t;

    localparam ticks_t TICKS_RESET = 8'd32;

    // Register index (word address)
    localparam logic [0:0] REG_SAMPLE_TICKS = 1'b0;

    // How the back end treats one queued capture
    typedef enum logic [1:0] {
        KIND_HOLD  = 2'd0,   // even element, no edge yet
        KIND_FIRST = 2'd1,   // first pair: odd sets reference, even is an edge
        KIND_PAIR  = 2'd2    // later pair: odd edge, then even edge
    } kind_t;

    typedef struct packed {
        cap_t  capture;
        cap_t  held;
        kind_t kind;
        logic  last;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } q_beat_t;

    localparam nibble_t GCR_TABLE [0:31] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,  4'd0,
        4'd0, 4'd9, 4'd10, 4'd11, 4'd0, 4'd13, 4'd14, 4'd15,
        4'd0, 4'd0, 4'd2, 4'd3, 4'd0, 4'd5, 4'd6,  4'd7,
        4'd0, 4'd0, 4'd8, 4'd1, 4'd0, 4'd4, 4'd12, 4'd0
    };

endpackage

[rtl/gtcd_ifs.sv]
// ---------------------------------------------------------------------------
// gtcd channel interfaces
// Valid/ready channels for capture beats and decoded result beats.
// ---------------------------------------------------------------------------
interface gtcd_cap_if;
    logic              valid;
    logic              ready;
    gtcd_pkg::cap_t    capture;
    logic              last;

    modport source (output valid, output capture, output last, input ready);
    modport sink   (input valid, input capture, input last, output ready);
endinterface

interface gtcd_res_if;
    logic              valid;
    logic              ready;
    gtcd_pkg::value_t  telemetry_value;
    logic              invalid;

    modport source (output valid, output telemetry_value, output invalid, input ready);
    modport sink   (input valid, input telemetry_value, input invalid, output ready);
endinterface

[rtl/gcr_telemetry_capture_decoder.sv]
// ---------------------------------------------------------------------------
// gcr_telemetry_capture_decoder
// GCR telemetry decoder fed with pair-swapped edge capture timestamps.
// ---------------------------------------------------------------------------
//
//   channel      dir   beat payload                       handshake
//   capture_ch   in    capture[15:0], last                valid/ready
//   result_ch    out   telemetry_value[11:0], invalid     valid/ready
//   apb          in    sample_ticks at byte address 0     psel/penable, pready = 1
//
// Flow: a capture beat is tagged and queued in its accept cycle. The back end
//   pops each queued beat in its idle state, then for each used edge runs setup,
//   a 5-step restoring divide for the run length and append; an edge that comes
//   after the frame is full only passes setup. A last beat adds the closing run
//   and decode steps. An odd beat of a later pair carries both edges of the pair.
// Reset: rst_n clears the pair tracking, queue, frame state and output beat;
//   sample_ticks comes up at 32.
// Stalls: capture_ch.ready drops only when the queue is full; a held result
//   beat blocks only the decode step, earlier steps keep running.
// ---------------------------------------------------------------------------
module gcr_telemetry_capture_decoder #(
    parameter int QUEUE_DEPTH = gtcd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gtcd_pkg::APB_ADDR_W-1:0]    paddr,
    input  gtcd_pkg::apb_data_t                pwdata,
    output gtcd_pkg::apb_data_t                prdata,
    output logic                               pready,
    // data channels
    gtcd_cap_if.sink                           capture_ch,
    gtcd_res_if.source                         result_ch
);

    gtcd_pkg::ticks_t  sample_ticks_reg, sample_ticks_next;
    logic [0:0]        reg_idx;
    logic              cfg_write;
    gtcd_pkg::q_beat_t push;
    gtcd_pkg::q_beat_t head;
    logic              queue_full;
    logic              pop;

    // APB register: single word, zero wait states
    assign pready    = 1'b1;
    assign reg_idx   = paddr[gtcd_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        sample_ticks_next = sample_ticks_reg;
        if (cfg_write && (reg_idx == gtcd_pkg::REG_SAMPLE_TICKS))
        begin
            sample_ticks_next = pwdata[gtcd_pkg::TICKS_W-1:0];
        end
    end

    always_comb
    begin
        case (reg_idx)
            gtcd_pkg::REG_SAMPLE_TICKS: prdata = gtcd_pkg::apb_data_t'(sample_ticks_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ticks_reg <= gtcd_pkg::TICKS_RESET;
        end
        else
        begin
            sample_ticks_reg <= sample_ticks_next;
        end
    end

    // Front end: pair tracking and tagging of every capture beat
    gtcd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .capture_ch (capture_ch),
        .queue_full (queue_full),
        .push       (push)
    );

    // Decoupling queue: front keeps accepting while the divider is busy, until it fills
    gtcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (queue_full)
    );

    // Back end: run lengths, frame assembly, decode, output register
    gtcd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_ticks (sample_ticks_reg),
        .head         (head),
        .pop          (pop),
        .result_ch    (result_ch)
    );

endmodule

[rtl/gtcd_front.sv]
// ---------------------------------------------------------------------------
// gtcd_front
// Accepts capture beats, tracks pair order and tags each beat for the back end.
// ---------------------------------------------------------------------------
module gtcd_front (
    input  logic                clk,
    input  logic                rst_n,
    gtcd_cap_if.sink            capture_ch,
    input  logic                queue_full,
    output gtcd_pkg::q_beat_t   push
);

    logic           pos_reg, pos_next;       // 1: odd element next
    logic           first_reg, first_next;   // first pair of the frame
    gtcd_pkg::cap_t held_reg, held_next;
    logic           accept;

    assign capture_ch.ready = !queue_full;
    assign accept           = capture_ch.valid && !queue_full;

    always_comb
    begin
        push.valid         = accept;
        push.entry.capture = capture_ch.capture;
        push.entry.held    = held_reg;
        push.entry.last    = capture_ch.last;
        if (!pos_reg)
        begin
            push.entry.kind = gtcd_pkg::KIND_HOLD;
        end
        else if (first_reg)
        begin
            push.entry.kind = gtcd_pkg::KIND_FIRST;
        end
        else
        begin
            push.entry.kind = gtcd_pkg::KIND_PAIR;
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        first_next = first_reg;
        held_next  = held_reg;
        if (accept)
        begin
            if (!pos_reg)
            begin
                held_next = capture_ch.capture;
                pos_next  = 1'b1;
            end
            else
            begin
                pos_next   = 1'b0;
                first_next = 1'b0;
            end
            if (capture_ch.last)
            begin
                pos_next   = 1'b0;
                first_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 1'b0;
            first_reg <= 1'b1;
        end
        else
        begin
            pos_reg   <= pos_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

[rtl/gtcd_queue.sv]
// ---------------------------------------------------------------------------
// gtcd_queue
// Small FIFO of tagged captures between the front and back ends.
// ---------------------------------------------------------------------------
module gtcd_queue #(
    parameter int DEPTH = gtcd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gtcd_pkg::q_beat_t   push,
    input  logic                pop,
    output gtcd_pkg::q_beat_t   head,
    output logic                full
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    typedef logic [PTR_W-1:0]   ptr_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam ptr_t   PTR_LAST  = ptr_t'(DEPTH - 1);
    localparam count_t COUNT_MAX = count_t'(DEPTH);

    gtcd_pkg::entry_t slots [DEPTH];
    ptr_t   wr_ptr_reg, wr_ptr_next;
    ptr_t   rd_ptr_reg, rd_ptr_next;
    count_t count_reg, count_next;
    logic   do_push, do_pop;

    assign full       = (count_reg == COUNT_MAX);
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.entry = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + ptr_t'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + ptr_t'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + count_t'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - count_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

[rtl/gtcd_back.sv]
// ---------------------------------------------------------------------------
// gtcd_back
// Turns edge gaps into GCR runs, closes the frame, decodes and checks it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module gtcd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  gtcd_pkg::ticks_t    sample_ticks,
    input  gtcd_pkg::q_beat_t   head,
    output logic                pop,
    gtcd_res_if.source          result_ch
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SETUP  = 6'b000010,
        S_DIV    = 6'b000100,
        S_APPEND = 6'b001000,
        S_CLOSE  = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    localparam gtcd_pkg::total_t FRAME_TOTAL = gtcd_pkg::total_t'(gtcd_pkg::FRAME_BITS);
    localparam gtcd_pkg::rem_t   RUN_LIMIT   = gtcd_pkg::rem_t'(gtcd_pkg::FRAME_BITS + 1);
    localparam gtcd_pkg::nibble_t CSUM_OK    = '1;

    state_t               state_reg, state_next;
    gtcd_pkg::cap_t       ref_reg, ref_next;
    gtcd_pkg::cap_t       cap_w_reg, cap_w_next;
    gtcd_pkg::cap_t       held_w_reg, held_w_next;
    logic                 last_w_reg, last_w_next;
    logic                 on_held_reg, on_held_next;
    gtcd_pkg::frame_t     sr_reg, sr_next;
    gtcd_pkg::total_t     total_reg, total_next;
    logic                 full_reg, full_next;
    logic                 err_reg, err_next;
    gtcd_pkg::rem_t       rem_reg, rem_next;
    gtcd_pkg::total_t     q_reg, q_next;
    gtcd_pkg::cnt_t       cnt_reg, cnt_next;
    logic                 res_valid_reg, res_valid_next;
    gtcd_pkg::value_t     value_reg, value_next;
    logic                 invalid_reg, invalid_next;

    gtcd_pkg::ticks_t     ticks;
    gtcd_pkg::cap_t       edge_val;
    gtcd_pkg::cap_t       gap;
    gtcd_pkg::num_t       num;
    gtcd_pkg::rem_t       limit;
    logic                 zero_run, over_run;
    gtcd_pkg::rem_t       dshift;
    logic                 take;
    gtcd_pkg::total_t     app_len;
    gtcd_pkg::total_sum_t run_sum;
    logic                 fits;
    gtcd_pkg::frame_t     appended;
    gtcd_pkg::dec_t       dec;
    gtcd_pkg::nibble_t    csum;
    logic                 bad;
    logic                 emit_go;
    state_t               after_edge;

    // Divisor and run-length datapath
    assign ticks    = (sample_ticks == '0) ? gtcd_pkg::ticks_t'(1) : sample_ticks;
    assign edge_val = on_held_reg ? held_w_reg : cap_w_reg;
    assign gap      = edge_val - ref_reg;
    assign num      = {1'b0, gap} + gtcd_pkg::num_t'(ticks >> 1);
    assign limit    = gtcd_pkg::rem_t'(ticks) * RUN_LIMIT;
    assign zero_run = num < gtcd_pkg::num_t'(ticks);
    assign over_run = num >= gtcd_pkg::num_t'(limit);
    assign dshift   = gtcd_pkg::rem_t'(ticks) << cnt_reg;
    assign take     = rem_reg >= dshift;

    // Shared run append: a one followed by len-1 zeros
    assign app_len  = state_reg[4] ? (FRAME_TOTAL - total_reg) : q_reg;
    assign run_sum  = {1'b0, total_reg} + {1'b0, app_len};
    assign fits     = run_sum <= gtcd_pkg::total_sum_t'(gtcd_pkg::FRAME_BITS);
    assign appended = (sr_reg << app_len)
                      | (gtcd_pkg::frame_t'(1) << (app_len - gtcd_pkg::total_t'(1)));

    // GCR decode and checksum
    assign dec  = {gtcd_pkg::GCR_TABLE[sr_reg[19:15]], gtcd_pkg::GCR_TABLE[sr_reg[14:10]],
                   gtcd_pkg::GCR_TABLE[sr_reg[9:5]],   gtcd_pkg::GCR_TABLE[sr_reg[4:0]]};
    assign csum = dec[3:0] ^ dec[7:4] ^ dec[11:8] ^ dec[15:12];
    assign bad  = err_reg || (total_reg != FRAME_TOTAL) || (csum != CSUM_OK);

    assign pop        = (state_reg == S_IDLE) && head.valid;
    assign emit_go    = (state_reg == S_EMIT) && (!res_valid_reg || result_ch.ready);
    assign after_edge = !on_held_reg ? S_SETUP : (last_w_reg ? S_CLOSE : S_IDLE);

    assign result_ch.valid           = res_valid_reg;
    assign result_ch.telemetry_value = value_reg;
    assign result_ch.invalid         = invalid_reg;

    always_comb
    begin
        state_next     = state_reg;
        ref_next       = ref_reg;
        cap_w_next     = cap_w_reg;
        held_w_next    = held_w_reg;
        last_w_next    = last_w_reg;
        on_held_next   = on_held_reg;
        sr_next        = sr_reg;
        total_next     = total_reg;
        full_next      = full_reg;
        err_next       = err_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg && !result_ch.ready;
        value_next     = value_reg;
        invalid_next   = invalid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    cap_w_next  = head.entry.capture;
                    held_w_next = head.entry.held;
                    last_w_next = head.entry.last;
                    case (head.entry.kind)
                        gtcd_pkg::KIND_FIRST:
                        begin
                            ref_next     = head.entry.capture;
                            on_held_next = 1'b1;
                            state_next   = S_SETUP;
                        end
                        gtcd_pkg::KIND_PAIR:
                        begin
                            on_held_next = 1'b0;
                            state_next   = S_SETUP;
                        end
                        default:
                        begin
                            state_next = head.entry.last ? S_CLOSE : S_IDLE;
                        end
                    endcase
                end
            end
            S_SETUP:
            begin
                if (full_reg)
                begin
                    on_held_next = 1'b1;
                    state_next   = after_edge;
                end
                else
                begin
                    ref_next = edge_val;
                    if (zero_run || over_run)
                    begin
                        err_next     = 1'b1;
                        full_next    = 1'b1;
                        on_held_next = 1'b1;
                        state_next   = after_edge;
                    end
                    else
                    begin
                        rem_next   = gtcd_pkg::rem_t'(num);
                        q_next     = '0;
                        cnt_next   = gtcd_pkg::cnt_t'(gtcd_pkg::DIV_STEPS - 1);
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (take)
                begin
                    rem_next = rem_reg - dshift;
                end
                q_next = {q_reg[gtcd_pkg::TOTAL_W-2:0], take};
                if (cnt_reg == '0)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    cnt_next = cnt_reg - gtcd_pkg::cnt_t'(1);
                end
            end
            S_APPEND:
            begin
                if (fits)
                begin
                    sr_next    = appended;
                    total_next = gtcd_pkg::total_t'(run_sum);
                    if (gtcd_pkg::total_t'(run_sum) == FRAME_TOTAL)
                    begin
                        full_next = 1'b1;
                    end
                end
                else
                begin
                    err_next  = 1'b1;
                    full_next = 1'b1;
                end
                on_held_next = 1'b1;
                state_next   = after_edge;
            end
            S_CLOSE:
            begin
                if (!err_reg && (total_reg < FRAME_TOTAL))
                begin
                    sr_next    = appended;
                    total_next = FRAME_TOTAL;
                    full_next  = 1'b1;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    res_valid_next = 1'b1;
                    value_next     = bad ? '0 : dec[15:4];
                    invalid_next   = bad;
                    ref_next       = '0;
                    sr_next        = '0;
                    total_next     = '0;
                    full_next      = 1'b0;
                    err_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ref_reg       <= '0;
            on_held_reg   <= 1'b0;
            last_w_reg    <= 1'b0;
            sr_reg        <= '0;
            total_reg     <= '0;
            full_reg      <= 1'b0;
            err_reg       <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ref_reg       <= ref_next;
            on_held_reg   <= on_held_next;
            last_w_reg    <= last_w_next;
            sr_reg        <= sr_next;
            total_reg     <= total_next;
            full_reg      <= full_next;
            err_reg       <= err_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_w_reg   <= cap_w_next;
        held_w_reg  <= held_w_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        value_reg   <= value_next;
        invalid_reg <= invalid_next;
    end

    `GTCD_ASSERT_IMP(a_run_len_range, state_reg == S_APPEND, (q_reg != '0) && (q_reg <= FRAME_TOTAL), "run length out of range at append")
    `GTCD_ASSERT(a_total_bound, total_reg <= FRAME_TOTAL, "bit total above frame size")
    `GTCD_ASSERT_IMP(a_err_full, err_reg, full_reg, "run error without frame stop")
    `GTCD_ASSERT_NXT(a_emit_clears, emit_go, (total_reg == '0) && !full_reg && res_valid_reg, "frame not cleared after result")

endmodule
